### design/trs_tmb_pkg.sv
// Shared types and constants of the TRS transform matrix builder.
`timescale 1ns / 1ps
`default_nettype none

package trs_tmb_pkg;

    // Width of one Q16.16 matrix element, position or scale
    localparam int VALUE_W         = 32;
    // Width of one quaternion component
    localparam int QUAT_W          = 16;
    // Fraction bits of position, scale and matrix elements
    localparam int VALUE_FRAC_BITS = 16;
    // Default fraction bits of the quaternion components
    localparam int QUAT_FRAC_BITS  = 14;
    // Register stages of the element scaling unit
    localparam int ELEM_LAT        = 4;

    // One scaled matrix element leaving the scaling unit
    typedef struct packed {
        logic               valid;
        logic               sat;
        logic [VALUE_W-1:0] value;
    } t_elem_res;

endpackage

`default_nettype wire

### design/trs_tmb_elem_scale.sv
// Scaling unit: rotation element times column scale, rounded and saturated to Q16.16.
`timescale 1ns / 1ps
`default_nettype none

module trs_tmb_elem_scale
    import trs_tmb_pkg::*;
#(
    parameter int QUAT_FRAC_BITS = trs_tmb_pkg::QUAT_FRAC_BITS,
    parameter int RW             = ((2 * QUAT_FRAC_BITS > 32) ? 2 * QUAT_FRAC_BITS : 32) + 2
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire logic signed [RW-1:0]      i_r,
    input  wire logic signed [VALUE_W-1:0] i_scale,
    output t_elem_res                      o_res
);

    localparam int RSHIFT = 2 * QUAT_FRAC_BITS;
    // Magnitude of an element, its high part and the full product
    localparam int MW     = RW - 1;
    localparam int HW     = MW - VALUE_W;
    localparam int PW     = MW + VALUE_W;
    localparam int SW     = PW - RSHIFT;

    logic [RW-1:0]      n_r_abs;
    logic [VALUE_W-1:0] n_s_abs;

    logic                 r_a_vld;
    logic                 r_a_neg;
    logic [MW-1:0]        r_a_mr;
    logic [VALUE_W-1:0]   r_a_ms;

    logic                 r_b_vld;
    logic                 r_b_neg;
    logic [2*VALUE_W-1:0] r_b_pl;
    logic [MW-1:0]        r_b_ph;

    logic                 r_c_vld;
    logic                 r_c_neg;
    logic [PW-1:0]        r_c_sum;

    logic [SW-1:0]        n_mag;
    logic [SW-1:0]        n_lim;
    logic                 n_sat;
    logic [VALUE_W-1:0]   n_val;

    logic                 r_res_vld;
    logic                 r_res_sat;
    logic [VALUE_W-1:0]   r_res_val;

    // Split both operands into sign and magnitude
    assign n_r_abs = i_r[RW-1] ? (RW'(0) - i_r) : i_r;
    assign n_s_abs = i_scale[VALUE_W-1] ? (VALUE_W'(0) - i_scale) : i_scale;

    // Advance valid bits of all stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_c_vld   <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            r_a_vld   <= i_valid;
            r_b_vld   <= r_a_vld;
            r_c_vld   <= r_b_vld;
            r_res_vld <= r_c_vld;
        end
    end

    // Stage A: hold magnitudes and the product sign
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_a_neg <= i_r[RW-1] ^ i_scale[VALUE_W-1];
            r_a_mr  <= n_r_abs[MW-1:0];
            r_a_ms  <= n_s_abs;
        end
    end

    // Stage B: low and high partial products
    always_ff @(posedge i_clk) begin
        if (r_a_vld) begin
            r_b_neg <= r_a_neg;
            r_b_pl  <= (2*VALUE_W)'(r_a_mr[VALUE_W-1:0]) * (2*VALUE_W)'(r_a_ms);
            r_b_ph  <= MW'(r_a_mr[MW-1:MW-HW]) * MW'(r_a_ms);
        end
    end

    // Stage C: join partial products and add the rounding half
    always_ff @(posedge i_clk) begin
        if (r_b_vld) begin
            r_c_neg <= r_b_neg;
            r_c_sum <= PW'(r_b_pl) + {r_b_ph, {VALUE_W{1'b0}}}
                       + (PW'(1) << (RSHIFT - 1));
        end
    end

    // Drop fraction bits, clamp to the signed range, restore the sign
    assign n_mag = r_c_sum[PW-1:RSHIFT];
    assign n_lim = r_c_neg ? (SW'(1) << (VALUE_W - 1))
                           : ((SW'(1) << (VALUE_W - 1)) - SW'(1));
    assign n_sat = (n_mag > n_lim);
    always_comb begin
        n_val = n_sat ? n_lim[VALUE_W-1:0] : n_mag[VALUE_W-1:0];
        if (r_c_neg) begin
            n_val = VALUE_W'(0) - n_val;
        end
    end

    // Stage D: hold the finished element
    always_ff @(posedge i_clk) begin
        if (r_c_vld) begin
            r_res_sat <= n_sat;
            r_res_val <= n_val;
        end
    end

    assign o_res = {r_res_vld, r_res_sat, r_res_val};

endmodule

`default_nettype wire

### design/trs_transform_matrix_builder_top.sv
// Top level of the TRS transform matrix builder: request sequencer and row pipeline.
`timescale 1ns / 1ps
`default_nettype none

// Builds the 4x4 model matrix T*R*S from a Q16.16 position, a Q1.14 quaternion
// (used as given, not normalized) and a Q16.16 per-axis scale. Each request
// gives four results, rows 0 to 3 on consecutive cycles, each marked by a
// one-cycle o_valid strobe; the receiver has no way to hold them, so it must
// take every strobe. A request is taken at a rising edge with i_start high and
// o_busy low. Rows enter the pipeline one per cycle, so the issue of four rows
// bounds how often requests are taken, and a new request is taken while the
// last row of the previous one is issued. Row 0 passes the product, rotation,
// scaling and output registers before it appears on the ports. Matrix elements
// are rounded half away from zero; an element outside the 32-bit range clamps
// and sets o_saturated for its row. Row 3 is always 0 0 0 1.
module trs_transform_matrix_builder_top
    import trs_tmb_pkg::*;
#(
    parameter int QUAT_FRAC_BITS = trs_tmb_pkg::QUAT_FRAC_BITS
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    output logic                           o_busy,
    input  wire logic signed [VALUE_W-1:0] i_pos_x,
    input  wire logic signed [VALUE_W-1:0] i_pos_y,
    input  wire logic signed [VALUE_W-1:0] i_pos_z,
    input  wire logic signed [QUAT_W-1:0]  i_quat_x,
    input  wire logic signed [QUAT_W-1:0]  i_quat_y,
    input  wire logic signed [QUAT_W-1:0]  i_quat_z,
    input  wire logic signed [QUAT_W-1:0]  i_quat_w,
    input  wire logic signed [VALUE_W-1:0] i_scale_x,
    input  wire logic signed [VALUE_W-1:0] i_scale_y,
    input  wire logic signed [VALUE_W-1:0] i_scale_z,
    output logic                           o_valid,
    output logic [1:0]                     o_row_index,
    output logic signed [VALUE_W-1:0]      o_col0,
    output logic signed [VALUE_W-1:0]      o_col1,
    output logic signed [VALUE_W-1:0]      o_col2,
    output logic signed [VALUE_W-1:0]      o_col3,
    output logic                           o_last_row,
    output logic                           o_saturated
);

    localparam int RSHIFT = 2 * QUAT_FRAC_BITS;
    localparam int RW     = ((RSHIFT > 32) ? RSHIFT : 32) + 2;
    localparam int PRW    = 2 * QUAT_W;

    // Matrix rows
    localparam logic [1:0] ROW_X = 2'd0;
    localparam logic [1:0] ROW_Y = 2'd1;
    localparam logic [1:0] ROW_Z = 2'd2;
    localparam logic [1:0] ROW_H = 2'd3;

    // How a rotation element is formed from its two products
    typedef enum logic [1:0] {
        OP_DIAG,
        OP_ADD,
        OP_SUB
    } t_elem_op;

    logic                       w_accept;

    // Request register and row sequencer
    logic                       r_active;
    logic [1:0]                 r_row;
    logic signed [VALUE_W-1:0]  r_pos   [3];
    logic signed [VALUE_W-1:0]  r_scale [3];
    logic signed [QUAT_W-1:0]   r_qx;
    logic signed [QUAT_W-1:0]   r_qy;
    logic signed [QUAT_W-1:0]   r_qz;
    logic signed [QUAT_W-1:0]   r_qw;

    // Operand selection for the issued row
    logic signed [QUAT_W-1:0]   n_a [3];
    logic signed [QUAT_W-1:0]   n_b [3];
    logic signed [QUAT_W-1:0]   n_c [3];
    logic signed [QUAT_W-1:0]   n_d [3];
    t_elem_op                   n_op [3];
    logic signed [VALUE_W-1:0]  n_pos;

    // Stage 1: quaternion products
    logic                       r_s1_vld;
    logic [1:0]                 r_s1_row;
    logic signed [VALUE_W-1:0]  r_s1_pos;
    logic signed [VALUE_W-1:0]  r_s1_scale [3];
    logic signed [PRW-1:0]      r_s1_p1 [3];
    logic signed [PRW-1:0]      r_s1_p2 [3];
    t_elem_op                   r_s1_op [3];

    // Stage 2: rotation elements
    logic signed [RW-1:0]       n_r [3];
    logic                       r_s2_vld;
    logic [1:0]                 r_s2_row;
    logic signed [VALUE_W-1:0]  r_s2_pos;
    logic signed [VALUE_W-1:0]  r_s2_scale [3];
    logic signed [RW-1:0]       r_s2_r [3];

    // Side data alongside the scaling units
    logic [1:0]                 r_row_d [ELEM_LAT];
    logic signed [VALUE_W-1:0]  r_pos_d [ELEM_LAT];
    t_elem_res                  w_res [3];

    // Output register
    logic                       r_out_vld;
    logic [1:0]                 r_out_row;
    logic signed [VALUE_W-1:0]  r_out_col [4];
    logic                       r_out_sat;

    assign o_busy   = r_active && (r_row != ROW_H);
    assign w_accept = i_start && !o_busy;

    // Sequence four rows per request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_row    <= ROW_X;
        end else if (w_accept) begin
            r_active <= 1'b1;
            r_row    <= ROW_X;
        end else if (r_active) begin
            r_row <= r_row + 2'd1;
            if (r_row == ROW_H) begin
                r_active <= 1'b0;
            end
        end
    end

    // Hold the request fields
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pos[0]   <= i_pos_x;
            r_pos[1]   <= i_pos_y;
            r_pos[2]   <= i_pos_z;
            r_scale[0] <= i_scale_x;
            r_scale[1] <= i_scale_y;
            r_scale[2] <= i_scale_z;
            r_qx       <= i_quat_x;
            r_qy       <= i_quat_y;
            r_qz       <= i_quat_z;
            r_qw       <= i_quat_w;
        end
    end

    // Select the product pairs for each column of the issued row
    always_comb begin
        n_pos = '0;
        unique case (r_row)
            ROW_X: begin
                n_pos = r_pos[0];
                n_a[0] = r_qy; n_b[0] = r_qy; n_c[0] = r_qz; n_d[0] = r_qz;
                n_op[0] = OP_DIAG;
                n_a[1] = r_qx; n_b[1] = r_qy; n_c[1] = r_qw; n_d[1] = r_qz;
                n_op[1] = OP_SUB;
                n_a[2] = r_qx; n_b[2] = r_qz; n_c[2] = r_qw; n_d[2] = r_qy;
                n_op[2] = OP_ADD;
            end
            ROW_Y: begin
                n_pos = r_pos[1];
                n_a[0] = r_qx; n_b[0] = r_qy; n_c[0] = r_qw; n_d[0] = r_qz;
                n_op[0] = OP_ADD;
                n_a[1] = r_qx; n_b[1] = r_qx; n_c[1] = r_qz; n_d[1] = r_qz;
                n_op[1] = OP_DIAG;
                n_a[2] = r_qy; n_b[2] = r_qz; n_c[2] = r_qw; n_d[2] = r_qx;
                n_op[2] = OP_SUB;
            end
            ROW_Z: begin
                n_pos = r_pos[2];
                n_a[0] = r_qx; n_b[0] = r_qz; n_c[0] = r_qw; n_d[0] = r_qy;
                n_op[0] = OP_SUB;
                n_a[1] = r_qy; n_b[1] = r_qz; n_c[1] = r_qw; n_d[1] = r_qx;
                n_op[1] = OP_ADD;
                n_a[2] = r_qx; n_b[2] = r_qx; n_c[2] = r_qy; n_d[2] = r_qy;
                n_op[2] = OP_DIAG;
            end
            ROW_H: begin
                // Fixed row: the rotation elements are discarded at the output
                for (int j = 0; j < 3; j++) begin
                    n_a[j] = '0; n_b[j] = '0; n_c[j] = '0; n_d[j] = '0;
                    n_op[j] = OP_ADD;
                end
            end
        endcase
    end

    // Stage 1: advance valid, form the products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= r_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_active) begin
            r_s1_row <= r_row;
            r_s1_pos <= n_pos;
            for (int j = 0; j < 3; j++) begin
                r_s1_scale[j] <= r_scale[j];
                r_s1_p1[j]    <= PRW'(n_a[j]) * PRW'(n_b[j]);
                r_s1_p2[j]    <= PRW'(n_c[j]) * PRW'(n_d[j]);
                r_s1_op[j]    <= n_op[j];
            end
        end
    end

    // Combine products into rotation elements with 2*QUAT_FRAC_BITS fraction bits
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            unique case (r_s1_op[j])
                OP_DIAG: n_r[j] = (RW'(1) << RSHIFT)
                                  - ((RW'(r_s1_p1[j]) + RW'(r_s1_p2[j])) <<< 1);
                OP_ADD:  n_r[j] = (RW'(r_s1_p1[j]) + RW'(r_s1_p2[j])) <<< 1;
                OP_SUB:  n_r[j] = (RW'(r_s1_p1[j]) - RW'(r_s1_p2[j])) <<< 1;
                default: n_r[j] = '0;
            endcase
        end
    end

    // Stage 2: hold rotation elements and their scales
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_s2_row <= r_s1_row;
            r_s2_pos <= r_s1_pos;
            for (int j = 0; j < 3; j++) begin
                r_s2_scale[j] <= r_s1_scale[j];
                r_s2_r[j]     <= n_r[j];
            end
        end
    end

    // Scale each column of the row
    for (genvar g = 0; g < 3; g++) begin : g_col
        trs_tmb_elem_scale #(
            .QUAT_FRAC_BITS (QUAT_FRAC_BITS),
            .RW             (RW)
        ) u_scale (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (r_s2_vld),
            .i_r     (r_s2_r[g]),
            .i_scale (r_s2_scale[g]),
            .o_res   (w_res[g])
        );
    end

    // Carry row index and position past the scaling units
    always_ff @(posedge i_clk) begin
        r_row_d[0] <= r_s2_row;
        r_pos_d[0] <= r_s2_pos;
        for (int k = 1; k < ELEM_LAT; k++) begin
            r_row_d[k] <= r_row_d[k-1];
            r_pos_d[k] <= r_pos_d[k-1];
        end
    end

    // Output stage: assemble the row, force the fixed last row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= w_res[0].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res[0].valid) begin
            r_out_row <= r_row_d[ELEM_LAT-1];
            if (r_row_d[ELEM_LAT-1] == ROW_H) begin
                r_out_col[0] <= '0;
                r_out_col[1] <= '0;
                r_out_col[2] <= '0;
                r_out_col[3] <= VALUE_W'(1) << VALUE_FRAC_BITS;
                r_out_sat    <= 1'b0;
            end else begin
                r_out_col[0] <= w_res[0].value;
                r_out_col[1] <= w_res[1].value;
                r_out_col[2] <= w_res[2].value;
                r_out_col[3] <= r_pos_d[ELEM_LAT-1];
                r_out_sat    <= w_res[0].sat | w_res[1].sat | w_res[2].sat;
            end
        end
    end

    assign o_valid     = r_out_vld;
    assign o_row_index = r_out_row;
    assign o_col0      = r_out_col[0];
    assign o_col1      = r_out_col[1];
    assign o_col2      = r_out_col[2];
    assign o_col3      = r_out_col[3];
    assign o_last_row  = (r_out_row == ROW_H);
    assign o_saturated = r_out_sat;

    // A taken request keeps the block busy while its rows are issued
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_busy)
        else $error("busy not raised after a request was taken");

    // Rows of one request leave on consecutive cycles in order
    a_rows_in_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_row_index != ROW_H))
        |=> (o_valid && (o_row_index == 2'($past(o_row_index) + 2'd1))))
        else $error("matrix rows out of order or interrupted");

    // The fixed last row never reports a clamp
    a_last_row_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_row) |-> !o_saturated)
        else $error("saturation flagged on the fixed last row");

    // Row 0 held in the rotation stage reaches the output strobe as row 0
    a_row0_follows_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_vld && (r_s2_row == ROW_X)) |-> ##5 (o_valid && (o_row_index == ROW_X)))
        else $error("row 0 lost between rotation stage and output");

endmodule

`default_nettype wire

### tb/sv/tb_trs_transform_matrix_builder_top.sv
// Testbench of the TRS transform matrix builder: queued requests, row predictor and row checker.
`timescale 1ns / 1ps

module tb_trs_transform_matrix_builder_top;
    import trs_tmb_pkg::*;

    localparam int ROT_SHIFT    = 2 * QUAT_FRAC_BITS;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_TICKS = 24;
    localparam int PHASE_REQS   = 131;
    localparam int unsigned PHASE_IDLE [3] = '{47, 0, 33};

    localparam logic signed [VALUE_W-1:0] ONE_Q16 = 32'sh0001_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [QUAT_W-1:0]  Q_ONE   = 16'sd16384;
    localparam logic signed [QUAT_W-1:0]  Q_MAX   = 16'sh7FFF;
    localparam logic signed [QUAT_W-1:0]  Q_MIN   = 16'sh8000;

    // One transform request plus how the driver should pace it
    typedef struct {
        logic signed [VALUE_W-1:0] pos_x, pos_y, pos_z;
        logic signed [QUAT_W-1:0]  quat_x, quat_y, quat_z, quat_w;
        logic signed [VALUE_W-1:0] scale_x, scale_y, scale_z;
        int unsigned               idle_pct;
        bit                        drain_first;
    } t_trs_req;

    // One matrix row as it leaves the block
    typedef struct packed {
        logic [1:0]         row_index;
        logic [VALUE_W-1:0] col0;
        logic [VALUE_W-1:0] col1;
        logic [VALUE_W-1:0] col2;
        logic [VALUE_W-1:0] col3;
        logic               last_row;
        logic               saturated;
    } t_matrix_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    logic signed [VALUE_W-1:0] i_pos_x   = '0;
    logic signed [VALUE_W-1:0] i_pos_y   = '0;
    logic signed [VALUE_W-1:0] i_pos_z   = '0;
    logic signed [QUAT_W-1:0]  i_quat_x  = '0;
    logic signed [QUAT_W-1:0]  i_quat_y  = '0;
    logic signed [QUAT_W-1:0]  i_quat_z  = '0;
    logic signed [QUAT_W-1:0]  i_quat_w  = '0;
    logic signed [VALUE_W-1:0] i_scale_x = '0;
    logic signed [VALUE_W-1:0] i_scale_y = '0;
    logic signed [VALUE_W-1:0] i_scale_z = '0;

    logic                      o_busy;
    logic                      o_valid;
    logic [1:0]                o_row_index;
    logic signed [VALUE_W-1:0] o_col0;
    logic signed [VALUE_W-1:0] o_col1;
    logic signed [VALUE_W-1:0] o_col2;
    logic signed [VALUE_W-1:0] o_col3;
    logic                      o_last_row;
    logic                      o_saturated;

    t_trs_req    req_backlog [$];
    t_matrix_row rows_due [$];
    t_trs_req    active_req;
    t_matrix_row row_want;
    bit          drv_free;
    bit          drv_load;
    int          mismatch_count = 0;
    int          cycle_count    = 0;

    trs_transform_matrix_builder_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_pos_z     (i_pos_z),
        .i_quat_x    (i_quat_x),
        .i_quat_y    (i_quat_y),
        .i_quat_z    (i_quat_z),
        .i_quat_w    (i_quat_w),
        .i_scale_x   (i_scale_x),
        .i_scale_y   (i_scale_y),
        .i_scale_z   (i_scale_z),
        .o_valid     (o_valid),
        .o_row_index (o_row_index),
        .o_col0      (o_col0),
        .o_col1      (o_col1),
        .o_col2      (o_col2),
        .o_col3      (o_col3),
        .o_last_row  (o_last_row),
        .o_saturated (o_saturated)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Scale one exact rotation entry, round half away from zero, clamp to 32 bits
    function automatic logic [VALUE_W-1:0] scale_element(input longint rot,
                                                         input logic signed [VALUE_W-1:0] s,
                                                         inout logic sat);
        logic signed [95:0] prod;
        logic [95:0]        mag;
        logic [95:0]        limit;
        logic               neg;
        prod  = rot * s;
        neg   = prod[95];
        mag   = neg ? -prod : prod;
        mag   = (mag + (96'd1 << (ROT_SHIFT - 1))) >> ROT_SHIFT;
        limit = neg ? 96'h8000_0000 : 96'h7FFF_FFFF;
        if (mag > limit) begin
            sat = 1'b1;
            mag = limit;
        end
        return neg ? -mag[VALUE_W-1:0] : mag[VALUE_W-1:0];
    endfunction

    // Work out the four rows of T*R*S for one request and queue them
    function automatic void queue_matrix_rows(input t_trs_req req);
        longint                    qx, qy, qz, qw, one_q;
        longint                    rot [3][3];
        logic signed [VALUE_W-1:0] scl [3];
        logic [VALUE_W-1:0]        posv [3];
        logic [VALUE_W-1:0]        elem [3];
        logic                      sat;
        t_matrix_row               row;
        qx    = req.quat_x;
        qy    = req.quat_y;
        qz    = req.quat_z;
        qw    = req.quat_w;
        one_q = longint'(1) << ROT_SHIFT;
        rot[0][0] = one_q - 2 * (qy * qy + qz * qz);
        rot[0][1] = 2 * (qx * qy - qw * qz);
        rot[0][2] = 2 * (qx * qz + qw * qy);
        rot[1][0] = 2 * (qx * qy + qw * qz);
        rot[1][1] = one_q - 2 * (qx * qx + qz * qz);
        rot[1][2] = 2 * (qy * qz - qw * qx);
        rot[2][0] = 2 * (qx * qz - qw * qy);
        rot[2][1] = 2 * (qy * qz + qw * qx);
        rot[2][2] = one_q - 2 * (qx * qx + qy * qy);
        scl  = '{req.scale_x, req.scale_y, req.scale_z};
        posv = '{req.pos_x, req.pos_y, req.pos_z};
        for (int i = 0; i < 3; i++) begin
            sat = 1'b0;
            for (int j = 0; j < 3; j++) begin
                elem[j] = scale_element(rot[i][j], scl[j], sat);
            end
            row.row_index = 2'(i);
            row.col0      = elem[0];
            row.col1      = elem[1];
            row.col2      = elem[2];
            row.col3      = posv[i];
            row.last_row  = 1'b0;
            row.saturated = sat;
            rows_due.push_back(row);
        end
        // Bottom row is fixed at 0 0 0 1
        row.row_index = 2'd3;
        row.col0      = '0;
        row.col1      = '0;
        row.col2      = '0;
        row.col3      = VALUE_W'(1) << VALUE_FRAC_BITS;
        row.last_row  = 1'b1;
        row.saturated = 1'b0;
        rows_due.push_back(row);
    endfunction

    function automatic t_trs_req make_request(
        input logic signed [VALUE_W-1:0] px, py, pz,
        input logic signed [QUAT_W-1:0]  qx, qy, qz, qw,
        input logic signed [VALUE_W-1:0] sx, sy, sz
    );
        t_trs_req req;
        req.pos_x       = px;
        req.pos_y       = py;
        req.pos_z       = pz;
        req.quat_x      = qx;
        req.quat_y      = qy;
        req.quat_z      = qz;
        req.quat_w      = qw;
        req.scale_x     = sx;
        req.scale_y     = sy;
        req.scale_z     = sz;
        req.idle_pct    = 20;
        req.drain_first = 1'b0;
        return req;
    endfunction

    function automatic int span(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // Mostly plausible transforms, the rest full-range codes that drive clamping
    function automatic t_trs_req random_request(input int unsigned idle_pct);
        t_trs_req req;
        req = make_request($urandom, $urandom, $urandom,
                           QUAT_W'($urandom), QUAT_W'($urandom),
                           QUAT_W'($urandom), QUAT_W'($urandom),
                           $urandom, $urandom, $urandom);
        if ($urandom_range(99) < 70) begin
            req.quat_x  = QUAT_W'(span(-16384, 16384));
            req.quat_y  = QUAT_W'(span(-16384, 16384));
            req.quat_z  = QUAT_W'(span(-16384, 16384));
            req.quat_w  = QUAT_W'(span(-16384, 16384));
            req.scale_x = span(-(1 << 19), 1 << 19);
            req.scale_y = span(-(1 << 19), 1 << 19);
            req.scale_z = span(-(1 << 19), 1 << 19);
        end
        req.idle_pct    = idle_pct;
        req.drain_first = ($urandom_range(99) < 2);
        return req;
    endfunction

    task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
                               input logic [VALUE_W-1:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // Drive requests from the backlog; queue the rows of each accepted one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            drv_free = !i_start;
            if (i_start && !o_busy) begin
                queue_matrix_rows(active_req);
                drv_free = 1'b1;
            end
            if (drv_free) begin
                drv_load = 1'b0;
                if (req_backlog.size() != 0 &&
                    !(req_backlog[0].drain_first && rows_due.size() != 0)) begin
                    drv_load = ($urandom_range(99) >= req_backlog[0].idle_pct);
                end
                if (drv_load) begin
                    active_req = req_backlog.pop_front();
                    i_pos_x   <= active_req.pos_x;
                    i_pos_y   <= active_req.pos_y;
                    i_pos_z   <= active_req.pos_z;
                    i_quat_x  <= active_req.quat_x;
                    i_quat_y  <= active_req.quat_y;
                    i_quat_z  <= active_req.quat_z;
                    i_quat_w  <= active_req.quat_w;
                    i_scale_x <= active_req.scale_x;
                    i_scale_y <= active_req.scale_y;
                    i_scale_z <= active_req.scale_z;
                end
                i_start <= drv_load;
            end
        end
    end

    // Compare every strobed row with the oldest expected row
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid !== 1'b0) begin
            if (rows_due.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected row: expected none, actual row %0d", $time,
                         o_row_index);
            end else begin
                row_want = rows_due.pop_front();
                check_field("row_index", 32'(row_want.row_index), 32'(o_row_index));
                check_field("col0", row_want.col0, o_col0);
                check_field("col1", row_want.col1, o_col1);
                check_field("col2", row_want.col2, o_col2);
                check_field("col3", row_want.col3, o_col3);
                check_field("last_row", 32'(row_want.last_row), 32'(o_last_row));
                check_field("saturated", 32'(row_want.saturated), 32'(o_saturated));
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        t_trs_req req;

        // Directed: identity, extremes of every field, rounding ties, clamping
        req_backlog.push_back(make_request(0, 0, 0, 0, 0, 0, Q_ONE,
                                           ONE_Q16, ONE_Q16, ONE_Q16));
        req_backlog.push_back(make_request(VAL_MAX, VAL_MIN, -1, 0, 0, 0, Q_ONE,
                                           ONE_Q16, ONE_Q16, ONE_Q16));
        req_backlog.push_back(make_request(ONE_Q16, 2 * ONE_Q16, -ONE_Q16, 0, 0, 0, 0,
                                           3 * ONE_Q16, -ONE_Q16, ONE_Q16 / 2));
        req_backlog.push_back(make_request(0, 0, 0, Q_ONE, 0, 0, 0,
                                           2 * ONE_Q16, -(7 * ONE_Q16 / 2), ONE_Q16 / 4));
        req_backlog.push_back(make_request(5, -5, 0, 0, 0, 16'sd11585, 16'sd11585,
                                           ONE_Q16, ONE_Q16, ONE_Q16));
        // Exact ties round away from zero, just under a tie rounds down
        req_backlog.push_back(make_request(0, 0, 0, 1, 1, 0, 0,
                                           ONE_Q16, 1 << 26, ONE_Q16));
        req_backlog.push_back(make_request(0, 0, 0, 1, 1, 0, 0,
                                           ONE_Q16, -(1 << 26), ONE_Q16));
        req_backlog.push_back(make_request(0, 0, 0, 1, 1, 0, 0,
                                           ONE_Q16, (1 << 26) - 1, ONE_Q16));
        // Most negative quaternion code on every component, both scale extremes
        req_backlog.push_back(make_request(VAL_MIN, VAL_MAX, 0, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                                           VAL_MAX, VAL_MAX, VAL_MAX));
        req_backlog.push_back(make_request(0, 0, 0, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                                           VAL_MIN, VAL_MIN, VAL_MIN));
        req_backlog.push_back(make_request(1, 2, 3, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                           VAL_MAX, VAL_MIN, VAL_MAX));
        req_backlog.push_back(make_request(0, 0, 0, Q_MIN, Q_MIN, 0, 0,
                                           ONE_Q16, ONE_Q16, ONE_Q16));
        req_backlog.push_back(make_request(0, 0, 0, Q_MIN, Q_MIN, 0, 0,
                                           VAL_MAX, VAL_MAX, VAL_MIN));
        // Largest in-range scale passes through without clamping
        req_backlog.push_back(make_request(0, 0, 0, 0, 0, 0, Q_MIN,
                                           VAL_MAX, VAL_MAX, VAL_MAX));
        req_backlog.push_back(make_request(0, 0, 0, 0, 0, 0, Q_ONE,
                                           VAL_MIN, VAL_MIN, VAL_MIN));
        req_backlog.push_back(make_request(VAL_MAX, VAL_MAX, VAL_MAX,
                                           Q_MIN, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0));
        req_backlog.push_back(make_request(-1, -1, -1, 16'sd1000, -16'sd2000,
                                           16'sd3000, -16'sd4000, -1, -1, -1));
        // Hold off until no rows are outstanding, then send with no idle gap
        req = make_request(7, 8, 9, 0, 0, 0, Q_ONE, ONE_Q16, ONE_Q16, ONE_Q16);
        req.drain_first = 1'b1;
        req.idle_pct    = 0;
        req_backlog.push_back(req);

        // Random phases with different sender gaps
        for (int phase = 0; phase < 3; phase++) begin
            for (int n = 0; n < PHASE_REQS; n++) begin
                req = random_request(PHASE_IDLE[phase]);
                if (n == 0) begin
                    req.drain_first = 1'b1;
                end
                req_backlog.push_back(req);
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (req_backlog.size() != 0 || i_start || rows_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_TICKS) @(posedge i_clk);

        if (mismatch_count == 0 && rows_due.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
